@@ rtl/frustum_box_visibility_assert.svh @@
// ----------------------------------------------------------------------------
// frustum box visibility assertion macros
// shared concurrent assertion forms for the culling pipeline
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_VISIBILITY_ASSERT_SVH
`define FRUSTUM_BOX_VISIBILITY_ASSERT_SVH

// property checked outside reset
`define FBV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked during reset as well
`define FBV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/fbv_pkg.sv @@
// ----------------------------------------------------------------------------
// fbv_pkg
// types and constants shared by the frustum box visibility pipeline
// ----------------------------------------------------------------------------
package fbv_pkg;

    localparam int REG_COUNT     = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int FIELD_W       = 16;
    localparam int FRAC_BITS     = 14;
    localparam int DTERM_W       = FIELD_W + FRAC_BITS;
    localparam int VIS_W         = 2;

    localparam logic [VIS_W-1:0] VIS_NONE    = 2'd0;
    localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
    localparam logic [VIS_W-1:0] VIS_FULL    = 2'd2;

    // load enables of the per-plane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

@@ rtl/fbv_plane_regs.sv @@
// ----------------------------------------------------------------------------
// fbv_plane_regs
// frustum plane configuration registers, one 64-bit word per plane
// ----------------------------------------------------------------------------
module fbv_plane_regs import fbv_pkg::*; #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [CFG_DATA_W-1:0] o_plane [PLANE_COUNT]
);

    logic [CFG_DATA_W-1:0] r_plane [PLANE_COUNT];

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        // planes past the register list stay zero and never cull
        localparam bit WRITABLE = (p < REG_COUNT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (WRITABLE && i_cfg_wr_en && i_cfg_index == CFG_IDX_W'(p)) begin
                r_plane[p] <= i_cfg_data;
            end
        end

        assign o_plane[p] = r_plane[p];
    end

endmodule

@@ rtl/fbv_plane_eval.sv @@
// ----------------------------------------------------------------------------
// fbv_plane_eval
// three-stage test of one box against one plane: products, per-axis
// min/max, then nearest and farthest corner distance signs
// ----------------------------------------------------------------------------
module fbv_plane_eval import fbv_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  t_stage_en                     i_en,
    input  logic [CFG_DATA_W-1:0]         i_plane,
    input  logic signed [COORD_WIDTH-1:0] i_lo [3],
    input  logic signed [COORD_WIDTH-1:0] i_hi [3],
    output logic                          o_all_out,
    output logic                          o_all_in
);

    localparam int PROD_W = COORD_WIDTH + FIELD_W;
    localparam int SUM_W  = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 3;

    logic signed [PROD_W-1:0] r_plo  [3];
    logic signed [PROD_W-1:0] r_phi  [3];
    logic signed [PROD_W-1:0] r_pmin [3];
    logic signed [PROD_W-1:0] r_pmax [3];
    logic                     r_all_out;
    logic                     r_all_in;

    logic signed [SUM_W-1:0]  n_min_sum;
    logic signed [SUM_W-1:0]  n_max_sum;
    logic signed [SUM_W-1:0]  dterm;
    logic [FIELD_W-1:0]       d_field;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [FIELD_W-1:0] nrm;
        assign nrm = i_plane[k*FIELD_W +: FIELD_W];

        always_ff @(posedge i_clk) begin
            if (i_en.s1) begin
                r_plo[k] <= PROD_W'(nrm) * PROD_W'(i_lo[k]);
                r_phi[k] <= PROD_W'(nrm) * PROD_W'(i_hi[k]);
            end
            if (i_en.s2) begin
                if (r_plo[k] < r_phi[k]) begin
                    r_pmin[k] <= r_plo[k];
                    r_pmax[k] <= r_phi[k];
                end else begin
                    r_pmin[k] <= r_phi[k];
                    r_pmax[k] <= r_plo[k];
                end
            end
        end
    end

    assign d_field = i_plane[3*FIELD_W +: FIELD_W];
    assign dterm   = {{(SUM_W-DTERM_W){d_field[FIELD_W-1]}}, d_field, FRAC_BITS'(0)};

    always_comb begin
        n_min_sum = dterm;
        n_max_sum = dterm;
        for (int k = 0; k < 3; k++) begin
            n_min_sum = n_min_sum + {{(SUM_W-PROD_W){r_pmin[k][PROD_W-1]}}, r_pmin[k]};
            n_max_sum = n_max_sum + {{(SUM_W-PROD_W){r_pmax[k][PROD_W-1]}}, r_pmax[k]};
        end
    end

    // farthest corner below zero: whole box outside; nearest at or above: inside
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_all_out <= n_max_sum[SUM_W-1];
            r_all_in  <= !n_min_sum[SUM_W-1];
        end
    end

    assign o_all_out = r_all_out;
    assign o_all_in  = r_all_in;

endmodule

@@ rtl/frustum_box_visibility.sv @@
// ----------------------------------------------------------------------------
// frustum_box_visibility
// classifies axis-aligned boxes against the view frustum planes
// ----------------------------------------------------------------------------
// Takes one box per clock while the output does not stall and returns its
// visibility (none, partial, full) in order. The five stages are the
// input register, one row of plane-normal multipliers (two per axis per
// plane, 16 x COORD_WIDTH bits), a per-axis min/max select, the four-term
// distance add with sign test, and the output register that merges the plane
// flags. Stalls on the output hold the pipeline in place and empty stages
// are filled while a result waits, so a steady stream runs at one box per
// cycle. Plane registers reset to zero, which makes every non-null box full.
module frustum_box_visibility import fbv_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int PLANE_COUNT = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_box_null,
    input  logic signed [COORD_WIDTH-1:0] i_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [VIS_W-1:0]              o_visibility
);

    `include "frustum_box_visibility_assert.svh"

    localparam int STAGES = 5;

    logic [CFG_DATA_W-1:0]         plane [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] r_lo  [3];
    logic signed [COORD_WIDTH-1:0] r_hi  [3];
    logic [STAGES-1:0]             r_vld;
    logic [STAGES-2:0]             r_null;
    logic [VIS_W-1:0]              r_vis;
    logic [VIS_W-1:0]              n_vis;
    logic [STAGES-1:0]             en;
    logic [PLANE_COUNT-1:0]        all_out;
    logic [PLANE_COUNT-1:0]        all_in;
    t_stage_en                     stage_en;

    fbv_plane_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_plane     (plane)
    );

    // a stage loads when empty or when the next stage takes its contents
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int s = STAGES-2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign stage_en.s1 = en[1];
    assign stage_en.s2 = en[2];
    assign stage_en.s3 = en[3];
    assign o_in_ready  = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_null[0] <= i_box_null;
            r_lo[0]   <= i_min_x;
            r_lo[1]   <= i_min_y;
            r_lo[2]   <= i_min_z;
            r_hi[0]   <= i_max_x;
            r_hi[1]   <= i_max_y;
            r_hi[2]   <= i_max_z;
        end
        for (int s = 1; s < STAGES-1; s++) begin
            if (en[s]) begin
                r_null[s] <= r_null[s-1];
            end
        end
        if (en[STAGES-1]) begin
            r_vis <= n_vis;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        fbv_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_eval (
            .i_clk     (i_clk),
            .i_en      (stage_en),
            .i_plane   (plane[p]),
            .i_lo      (r_lo),
            .i_hi      (r_hi),
            .o_all_out (all_out[p]),
            .o_all_in  (all_in[p])
        );
    end

    always_comb begin
        if (r_null[STAGES-2] || (|all_out)) begin
            n_vis = VIS_NONE;
        end else if (&all_in) begin
            n_vis = VIS_FULL;
        end else begin
            n_vis = VIS_PARTIAL;
        end
    end

    assign o_out_valid  = r_vld[STAGES-1];
    assign o_visibility = r_vis;

    `FBV_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "pipeline not empty after reset")
    `FBV_ASSERT(a_vis_code, i_clk, i_rst_n,
        o_out_valid |-> (o_visibility == VIS_NONE || o_visibility == VIS_PARTIAL ||
        o_visibility == VIS_FULL), "visibility code out of range")
    `FBV_ASSERT(a_null_none, i_clk, i_rst_n,
        r_vld[STAGES-2] && r_null[STAGES-2] && en[STAGES-1] |=> o_visibility == VIS_NONE,
        "null box not reported invisible")
    `FBV_ASSERT(a_stall_full, i_clk, i_rst_n,
        !o_in_ready |-> (o_out_valid && !i_out_ready && (&r_vld)),
        "input stalled while pipeline has room")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for frustum_box_visibility.
// ----------------------------------------------------------------------------
// Boxes go in through a valid/ready sender task. Results leave through a
// receiver process that stalls at random. Each box accepted by the block is
// classified by a local six-plane distance evaluator that uses the current
// plane settings. The visibility it predicts is queued and then compared
// with the results in order. The plane registers are rewritten between
// phases while the block is idle. The phases cover reset planes, an
// axis-aligned frustum, extreme planes, random frustums, a long output stall
// and a sender pause.
module tb_top;
    import fbv_pkg::*;

    localparam int COORD_W      = 16;
    localparam int PLANES       = 6;
    localparam int COORD_MIN    = -(2 ** (COORD_W - 1));
    localparam int COORD_MAX    = 2 ** (COORD_W - 1) - 1;
    localparam int UNIT         = 2 ** FRAC_BITS;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP, REG_BOTTOM, REG_LEFT, REG_RIGHT, REG_FAR, REG_NEAR, REG_SPARE6, REG_SPARE7
    } t_reg_index;

    typedef struct {
        bit                        is_null;
        logic signed [COORD_W-1:0] min_x, min_y, min_z;
        logic signed [COORD_W-1:0] max_x, max_y, max_z;
    } t_box;

    typedef struct {
        int               seq;
        logic [VIS_W-1:0] vis;
    } t_pending_vis;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      box_null = 1'b0;
    logic signed [COORD_W-1:0] min_x = '0, min_y = '0, min_z = '0;
    logic signed [COORD_W-1:0] max_x = '0, max_y = '0, max_z = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [VIS_W-1:0]          visibility;

    logic [CFG_DATA_W-1:0] plane_regs [PLANES];
    t_pending_vis          pending_vis [$];
    int                    boxes_sent = 0;
    int                    vis_errors = 0;
    int                    tx_burst_left = 0;
    int                    rx_burst_left = 0;
    bit                    tx_no_gaps = 1'b0;
    int                    rx_hold_cycles = 0;

    always #1 clk = ~clk;

    frustum_box_visibility #(
        .COORD_WIDTH (COORD_W),
        .PLANE_COUNT (PLANES)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_box_null   (box_null),
        .i_min_x      (min_x),
        .i_min_y      (min_y),
        .i_min_z      (min_z),
        .i_max_x      (max_x),
        .i_max_y      (max_y),
        .i_max_z      (max_z),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_visibility (visibility)
    );

    function automatic logic signed [63:0] plane_field(logic [63:0] r, int slot);
        logic signed [15:0] f;
        f = r[16*slot +: 16];
        return f;
    endfunction

    function automatic logic [VIS_W-1:0] classify_box(t_box b);
        logic signed [63:0] lo [3];
        logic signed [63:0] hi [3];
        logic signed [63:0] n [3];
        logic signed [63:0] dterm;
        logic signed [63:0] corner_dist;
        bit                 all_in;
        bit                 all_out;
        if (b.is_null) begin
            return VIS_NONE;
        end
        lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
        hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
        all_in = 1'b1;
        for (int p = 0; p < PLANES; p++) begin
            for (int k = 0; k < 3; k++) begin
                n[k] = plane_field(plane_regs[p], k);
            end
            dterm = plane_field(plane_regs[p], 3) <<< FRAC_BITS;
            all_out = 1'b1;
            for (int c = 0; c < 8; c++) begin
                corner_dist = dterm;
                for (int k = 0; k < 3; k++) begin
                    corner_dist = corner_dist +
                                  n[k] * ((((c >> k) & 1) != 0) ? hi[k] : lo[k]);
                end
                if (corner_dist < 0) begin
                    all_in = 1'b0;
                end else begin
                    all_out = 1'b0;
                end
            end
            if (all_out) begin
                return VIS_NONE;
            end
        end
        return all_in ? VIS_FULL : VIS_PARTIAL;
    endfunction

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int rand_between(int lo, int hi);
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    function automatic t_box make_box(bit nul, int x0, int y0, int z0, int x1, int y1, int z1);
        t_box b;
        b.is_null = nul;
        b.min_x = x0[COORD_W-1:0]; b.min_y = y0[COORD_W-1:0]; b.min_z = z0[COORD_W-1:0];
        b.max_x = x1[COORD_W-1:0]; b.max_y = y1[COORD_W-1:0]; b.max_z = z1[COORD_W-1:0];
        return b;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic t_box random_box();
        int  kind;
        int  cx, cy, cz, hx, hy, hz, span;
        bit  nul;
        kind = $urandom_range(0, 9);
        nul = ($urandom_range(0, 7) == 0);
        span = (kind <= 3) ? 3000 : 12000;
        cx = rand_between(-20000, 20000);
        cy = rand_between(-20000, 20000);
        cz = rand_between(-20000, 20000);
        hx = $urandom_range(0, span);
        hy = $urandom_range(0, span);
        hz = $urandom_range(0, span);
        if (kind <= 5) begin
            return make_box(nul, cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
        end else if (kind <= 7) begin
            return make_box(nul, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (kind == 8) begin
            return make_box(nul, extreme_coord(), extreme_coord(), extreme_coord(),
                            extreme_coord(), extreme_coord(), extreme_coord());
        end
        // min at or above max on every axis
        return make_box(nul, cx + hx, cy + hy, cz + hz, cx - hx, cy - hy, cz - hz);
    endfunction

    function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int d);
        return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
    endfunction

    task automatic send_box(input t_box b);
        int           gap;
        t_pending_vis want;
        gap = tx_no_gaps ? 0 : draw_wait(tx_burst_left);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_null <= b.is_null;
        min_x <= b.min_x; min_y <= b.min_y; min_z <= b.min_z;
        max_x <= b.max_x; max_y <= b.max_y; max_z <= b.max_z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        want.seq = boxes_sent;
        want.vis = classify_box(b);
        pending_vis.push_back(want);
        boxes_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx < REG_COUNT) begin
            plane_regs[idx] = data;
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_vis.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_box_frustum(input int xl, input int xh, input int yl, input int yh,
                                   input int zl, input int zh);
        write_reg(REG_TOP,    pack_plane(0, -UNIT, 0, yh));
        write_reg(REG_BOTTOM, pack_plane(0, UNIT, 0, -yl));
        write_reg(REG_LEFT,   pack_plane(UNIT, 0, 0, -xl));
        write_reg(REG_RIGHT,  pack_plane(-UNIT, 0, 0, xh));
        write_reg(REG_FAR,    pack_plane(0, 0, -UNIT, zh));
        write_reg(REG_NEAR,   pack_plane(0, 0, UNIT, -zl));
    endtask

    task automatic load_random_frustum();
        case ($urandom_range(0, 3))
            0: begin
                set_box_frustum(rand_between(-30000, -500), rand_between(500, 30000),
                                rand_between(-30000, -500), rand_between(500, 30000),
                                rand_between(-30000, -500), rand_between(500, 30000));
            end
            1: begin
                // tilted planes
                for (int i = 0; i < PLANES; i++) begin
                    write_reg(t_reg_index'(i), pack_plane(rand_between(-UNIT, UNIT),
                              rand_between(-UNIT, UNIT), rand_between(-UNIT, UNIT),
                              rand_between(-2000, 30000)));
                end
            end
            2: begin
                for (int i = 0; i < PLANES; i++) begin
                    write_reg(t_reg_index'(i), {$urandom, $urandom});
                end
            end
            default: begin
                set_box_frustum(rand_between(-30000, -500), rand_between(500, 30000),
                                rand_between(-30000, -500), rand_between(500, 30000),
                                rand_between(-30000, -500), rand_between(500, 30000));
                write_reg(t_reg_index'($urandom_range(0, PLANES - 1)), '0);
                write_reg(t_reg_index'($urandom_range(0, PLANES - 1)), {$urandom, $urandom});
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
        end
    endtask

    task automatic test_reset_state();
        send_box(make_box(0, 0, 0, 0, 0, 0, 0));
        send_box(make_box(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(1, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        wait_idle();
    endtask

    task automatic test_frustum_directed();
        set_box_frustum(-1000, 1000, -2000, 2000, -500, 3000);
        write_reg(REG_SPARE6, '1);
        write_reg(REG_SPARE7, {$urandom, $urandom});
        send_box(make_box(0, -10, -10, 0, 10, 10, 100));
        send_box(make_box(0, 1200, -10, 0, 1500, 10, 100));
        send_box(make_box(0, 900, -10, 0, 1100, 10, 100));
        send_box(make_box(0, -1000, -2000, -500, 1000, 2000, 3000));
        send_box(make_box(0, 1001, -10, 0, 1001, 10, 100));
        send_box(make_box(1, -10, -10, 0, 10, 10, 100));
        send_box(make_box(0, 10, 10, 100, -10, -10, 0));
        send_box(make_box(0, 1100, 10, 100, -10, -10, 0));
        send_box(make_box(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        wait_idle();
    endtask

    task automatic test_extreme_planes();
        logic [15:0] v;
        for (int s = 0; s < 2; s++) begin
            v = (s == 0) ? 16'h8000 : 16'h7fff;
            for (int i = 0; i < PLANES; i++) begin
                write_reg(t_reg_index'(i), {4{v}});
            end
            send_box(make_box(0, 0, 0, 0, 0, 0, 0));
            send_box(make_box(0, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN));
            send_box(make_box(0, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX));
            send_box(make_box(0, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MAX, COORD_MAX, COORD_MAX));
            send_box(make_box(1, 0, 0, 0, 0, 0, 0));
            wait_idle();
        end
    endtask

    task automatic test_random_boxes();
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                for (int i = 0; i < PLANES; i++) begin
                    write_reg(t_reg_index'(i), '0);
                end
            end else begin
                load_random_frustum();
            end
            repeat (100) send_box(random_box());
            wait_idle();
        end
    endtask

    task automatic test_output_stall();
        load_random_frustum();
        rx_hold_cycles = 300;
        tx_no_gaps = 1'b1;
        repeat (60) send_box(random_box());
        tx_no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_sender_pause();
        load_random_frustum();
        repeat (40) send_box(random_box());
        wait_idle();
        repeat (40) send_box(random_box());
        wait_idle();
    endtask

    // result checker
    always @(posedge clk) begin : check_results
        t_pending_vis want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_vis.size() == 0) begin
                if (vis_errors < 10) begin
                    $display("%0t unexpected transaction, visibility %0d", $realtime, visibility);
                end
                vis_errors++;
            end else begin
                want = pending_vis.pop_front();
                if (visibility !== want.vis) begin
                    if (vis_errors < 10) begin
                        $display("%0t box %0d: expected visibility %0d, got %0d",
                                 $realtime, want.seq, want.vis, visibility);
                    end
                    vis_errors++;
                end
            end
        end
    end

    // output side flow control
    initial begin : drive_out_ready
        int stall;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = draw_wait(rx_burst_left);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        for (int i = 0; i < PLANES; i++) begin
            plane_regs[i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_state();
        test_frustum_directed();
        test_extreme_planes();
        test_random_boxes();
        test_output_stall();
        test_sender_pause();
        if (vis_errors == 0 && pending_vis.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fbv_pkg.sv
rtl/fbv_plane_regs.sv
rtl/fbv_plane_eval.sv
rtl/frustum_box_visibility.sv
bench/tb_top.sv
